[design/hfo_pkg.sv]
`timescale 1ns / 1ps
package hfo_pkg;

  localparam int HOP_MAX_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // config port
  localparam int              CFG_W       = 7;
  localparam logic [CFG_W-1:0] HOP_LEN_RST = 7'd64;
  localparam int              ADDR_W      = 3;
  localparam int              DATA_W      = 32;
  localparam logic [0:0]      REG_HOP_LEN = 1'b0;

  // item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_END    = 1'b1;

  // fade gain fixed point (Q30)
  localparam int          QB     = 31;
  localparam int          Q_FRAC = 30;
  localparam logic [QB-1:0] Q_ONE  = 31'd1073741824;
  localparam logic [QB-1:0] COS_C1 = 31'd1324675879;
  localparam logic [QB-1:0] COS_C2 = 31'd272375560;
  localparam logic [QB-1:0] COS_C3 = 31'd22401992;
  localparam logic [QB-1:0] COS_C4 = 31'd987048;
  localparam logic [QB-1:0] COS_C5 = 31'd27060;
  localparam int          GAIN_W = 16;
  localparam int          SQ_W   = 2 * CFG_W;

  // Horner coefficient after multiply j (C4 first, C1 last)
  function automatic logic [QB-1:0] horner_coef(input logic [1:0] j);
    logic [QB-1:0] c;
    case (j)
      2'd0:    c = COS_C4;
      2'd1:    c = COS_C3;
      2'd2:    c = COS_C2;
      default: c = COS_C1;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic             tail;
    logic             bank;
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] hop;
  } hop_cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_CAP,
    BK_DIV,
    BK_MUL,
    BK_SUB,
    BK_GAIN,
    BK_SCALE,
    BK_EMIT
  } back_state_e;

endpackage

[design/hfo_ram.sv]
`timescale 1ns / 1ps
module hfo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/hfo_fifo.sv]
`timescale 1ns / 1ps
module hfo_fifo import hfo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hop_cmd_t data_i,
  input  logic     pop_i,
  output logic     empty_o,
  output hop_cmd_t data_o
);

  // two entries; the front never pushes into a full queue
  hop_cmd_t   slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

[design/hfo_front.sv]
`timescale 1ns / 1ps
module hfo_front import hfo_pkg::*; #(
  parameter int HOP_MAX     = HOP_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic [CFG_W-1:0]             hop_i,
  input  logic                         clear_i,
  input  logic                         done_i,
  output logic                         push_o,
  output hop_cmd_t                     cmd_o,
  output logic                         we_o,
  output logic [$clog2(HOP_MAX):0]     waddr_o,
  output logic [SAMPLE_BITS-1:0]       wdata_o
);

  localparam int IDX_W = $clog2(HOP_MAX);

  logic [CFG_W-1:0] fill_q, fill_d, fill_cur, fill_nxt;
  logic             bank_q, bank_d;
  logic [1:0]       pend_q, pend_d;   // hops queued or in emission
  logic             acc;

  // a bank is free once at most one hop is outstanding (it owns the other bank)
  assign in_ready_o = (pend_q != 2'd2);
  assign acc        = in_valid_i && in_ready_o;
  assign fill_cur   = (fill_q >= hop_i) ? '0 : fill_q;
  assign fill_nxt   = fill_cur + 1'b1;
  assign waddr_o    = {bank_q, fill_cur[IDX_W-1:0]};
  assign wdata_o    = sample_in_i;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    push_o = 1'b0;
    we_o   = 1'b0;
    cmd_o  = '{tail: 1'b0, bank: bank_q, n: hop_i, hop: hop_i};
    if (acc) begin
      if (func_i == FUNC_SAMPLE) begin
        we_o = 1'b1;
        if (fill_nxt == hop_i) begin
          push_o = 1'b1;
          fill_d = '0;
          bank_d = ~bank_q;
        end else begin
          fill_d = fill_nxt;
        end
      end else begin
        fill_d = '0;
        if (fill_q != '0 && fill_q < hop_i) begin
          push_o     = 1'b1;
          cmd_o.tail = 1'b1;
          cmd_o.n    = fill_q;
          bank_d     = ~bank_q;
        end
      end
    end
    if (clear_i) begin
      fill_d = '0;
    end
    pend_d = pend_q + 2'(push_o) - 2'(done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
      pend_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
      pend_q <= pend_d;
    end
  end

endmodule

[design/hfo_back.sv]
`timescale 1ns / 1ps
module hfo_back import hfo_pkg::*; #(
  parameter int HOP_MAX     = HOP_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  hop_cmd_t                      cmd_i,
  output logic                          pop_o,
  output logic [$clog2(HOP_MAX):0]      raddr_o,
  input  logic [SAMPLE_BITS-1:0]        rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          hop_last_o,
  output logic                          tail_hop_o,
  output logic                          done_o
);

  localparam int IDX_W = $clog2(HOP_MAX);
  localparam int NW    = SQ_W + Q_FRAC;
  localparam int SB    = SAMPLE_BITS;

  back_state_e state_q, state_d;

  hop_cmd_t           cmd_q;
  logic [CFG_W-1:0]   k_q;
  logic [SB-1:0]      smp_q, res_q;
  logic [SQ_W-1:0]    dsq_q, rem_q;
  logic [QB-1:0]      lo_q, t_q;
  logic [2*QB-1:0]    prod_q;
  logic [2:0]         j_q;
  logic [4:0]         dcnt_q;
  logic [GAIN_W-1:0]  gain_q;

  logic               out_valid_q;
  logic [SB-1:0]      out_smp_q;
  logic               out_last_q, out_tail_q;

  logic               out_free, is_last, need_gain;
  logic [CFG_W-1:0]   dm1;
  logic [SQ_W-1:0]    dsq, isq;
  logic [NW-1:0]      num;
  logic [SQ_W:0]      trial;
  logic               neg;
  logic [SB-1:0]      mag, rmag;
  logic [SB+GAIN_W:0] rnd;
  logic [QB-1:0]      gsum;

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_last   = (k_q == cmd_q.hop - 1'b1);
  assign need_gain = cmd_q.tail && (k_q < cmd_q.n) && (cmd_q.n > 7'd1);
  assign raddr_o   = {cmd_q.bank, k_q[IDX_W-1:0]};

  // divider operands: x2 = (k^2 * 2^30 + d^2/2) / d^2, d = n-1
  assign dm1   = cmd_q.n - 1'b1;
  assign dsq   = dm1 * dm1;
  assign isq   = k_q * k_q;
  assign num   = {isq, {Q_FRAC{1'b0}}} + NW'(dsq >> 1);
  assign trial = {rem_q, lo_q[QB-1]};

  assign neg  = smp_q[SB-1];
  assign mag  = neg ? (~smp_q + 1'b1) : smp_q;
  assign rnd  = (SB+GAIN_W+1)'(mag * gain_q) + (SB+GAIN_W+1)'(1 << 14);
  assign rmag = rnd[SB+14:15];
  assign gsum = Q_ONE - t_q + QB'(1 << 14);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!empty_i) state_d = BK_READ;
      BK_READ:  state_d = BK_CAP;
      BK_CAP:   state_d = need_gain ? BK_DIV : BK_EMIT;
      BK_DIV:   if (dcnt_q == 5'd0) state_d = BK_MUL;
      BK_MUL:   state_d = BK_SUB;
      BK_SUB:   state_d = (j_q == 3'd4) ? BK_GAIN : BK_MUL;
      BK_GAIN:  state_d = BK_SCALE;
      BK_SCALE: state_d = BK_EMIT;
      BK_EMIT:  if (out_free) state_d = is_last ? BK_IDLE : BK_READ;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    done_o = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o  = !empty_i;
      BK_EMIT: done_o = out_free && is_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        cmd_q <= cmd_i;
        k_q   <= '0;
      end
      BK_CAP: begin
        smp_q  <= rdata_i;
        res_q  <= (!cmd_q.tail || k_q < cmd_q.n) ? rdata_i : '0;
        dsq_q  <= dsq;
        rem_q  <= SQ_W'(num[NW-1:QB]);
        lo_q   <= num[QB-1:0];
        dcnt_q <= 5'(QB - 1);
        j_q    <= '0;
        t_q    <= COS_C5;
      end
      BK_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, dsq_q}) begin
          rem_q <= SQ_W'(trial - {1'b0, dsq_q});
          lo_q  <= {lo_q[QB-2:0], 1'b1};
        end else begin
          rem_q <= trial[SQ_W-1:0];
          lo_q  <= {lo_q[QB-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 1'b1;
      end
      BK_MUL: prod_q <= t_q * lo_q;
      BK_SUB: begin
        if (j_q == 3'd4) begin
          t_q <= prod_q[QB+Q_FRAC-1:Q_FRAC];
        end else begin
          t_q <= horner_coef(j_q[1:0]) - prod_q[QB+Q_FRAC-1:Q_FRAC];
        end
        j_q <= j_q + 1'b1;
      end
      BK_GAIN:  gain_q <= (t_q >= Q_ONE) ? '0 : gsum[QB-1:15];
      BK_SCALE: res_q  <= neg ? (~rmag + 1'b1) : rmag;
      BK_EMIT: begin
        if (out_free) begin
          out_smp_q  <= res_q;
          out_last_q <= is_last;
          out_tail_q <= cmd_q.tail;
          k_q        <= k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_smp_q;
  assign hop_last_o   = out_last_q;
  assign tail_hop_o   = out_tail_q;

endmodule

[design/hop_framer_with_tail_fadeout.sv]
`timescale 1ns / 1ps
// Timing: a full hop's command passes through the queue, and the back end steps IDLE, READ,
//   CAP, EMIT for its first word, READ, CAP, EMIT for each further word and IDLE between
//   hops; faded tail words add a 31-step divide, five multiply/subtract pairs, GAIN and SCALE.
// Throughput: one input word per cycle while fewer than two hops are outstanding; a
//   sustained stream is paced by the back end's sequencer, which handles one word at a time.
// Reset: rst_ni async active low; fill count, queue and output valid clear, hop_length -> 64.
module hop_framer_with_tail_fadeout import hfo_pkg::*; #(
  parameter int HOP_MAX     = HOP_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // output words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          hop_last_o,
  output logic                          tail_hop_o
);

  localparam int AW = $clog2(HOP_MAX) + 1;   // two banks of HOP_MAX

  logic [CFG_W-1:0]       hop_len_q, hop_eff;
  logic                   cfg_wr;
  logic                   push, pop, empty, done, we;
  hop_cmd_t               cmd_in, cmd_out;
  logic [AW-1:0]          waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;

  // register 0 at byte address 0; a write to it also drops a partial hop
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_HOP_LEN);
  assign prdata = (paddr[ADDR_W-1:2] == REG_HOP_LEN) ? DATA_W'(hop_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_len_q <= HOP_LEN_RST;
    end else if (cfg_wr) begin
      hop_len_q <= pwdata[CFG_W-1:0];
    end
  end

  // zero acts as one, oversize clamps to HOP_MAX
  assign hop_eff = (hop_len_q == '0) ? CFG_W'(1) :
                   (hop_len_q > CFG_W'(HOP_MAX)) ? CFG_W'(HOP_MAX) : hop_len_q;

  hfo_front #(.HOP_MAX(HOP_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .func_i, .sample_in_i,
    .hop_i   (hop_eff),
    .clear_i (cfg_wr),
    .done_i  (done),
    .push_o  (push),
    .cmd_o   (cmd_in),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata)
  );

  hfo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 * HOP_MAX)) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hfo_fifo u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  hfo_back #(.HOP_MAX(HOP_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .out_valid_o, .out_ready_i, .sample_out_o, .hop_last_o, .tail_hop_o,
    .done_o  (done)
  );

endmodule

[tb/sv/tb_hop_framer_with_tail_fadeout.sv]
`timescale 1ns / 1ps
module tb_hop_framer_with_tail_fadeout;
  import hfo_pkg::*;

  // one emitted output word as predicted
  typedef struct {
    logic [15:0] sample;
    logic        last;
    logic        tail;
  } hop_word_t;

  // Predicts the word stream of the framer and checks the words that come out.
  class hop_scoreboard;
    logic [15:0]  hop_mem[HOP_MAX_DEF];
    int unsigned  fill;
    logic [6:0]   hop_reg;
    hop_word_t    pending[$];
    int           errors;
    int           words_seen;
    int           tail_words;
    int           tail_hops;

    function new();
      hop_reg    = HOP_LEN_RST;
      fill       = 0;
      errors     = 0;
      words_seen = 0;
      tail_words = 0;
      tail_hops  = 0;
    endfunction

    function void write_hop(logic [31:0] v);
      hop_reg = v[6:0];
      fill    = 0;
    endfunction

    function int unsigned eff_hop();
      if (hop_reg == 0) return 1;
      if (hop_reg > HOP_MAX_DEF) return HOP_MAX_DEF;
      return hop_reg;
    endfunction

    // Q1.15 gain cos(pi/2 * i/d), Horner in Q30 with truncating shifts
    function int unsigned fade_gain(int unsigned i, int unsigned d);
      longint unsigned d2, x2, t, one;
      one = longint'(Q_ONE);
      d2  = longint'(d) * longint'(d);
      x2  = (((longint'(i) * longint'(i)) << 30) + d2 / 2) / d2;
      t   = longint'(COS_C4) - ((longint'(COS_C5) * x2) >> 30);
      t   = longint'(COS_C3) - ((t * x2) >> 30);
      t   = longint'(COS_C2) - ((t * x2) >> 30);
      t   = longint'(COS_C1) - ((t * x2) >> 30);
      t   = (t * x2) >> 30;
      if (t >= one) return 0;
      return int'(((one - t) + 64'd16384) >> 15);
    endfunction

    // sample * gain / 2^15, ties away from zero
    function logic [15:0] scale(logic signed [15:0] s, int unsigned g);
      longint mag, r;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      r   = (mag * longint'(g) + 16384) >>> 15;
      if (s < 0) r = -r;
      return r[15:0];
    endfunction

    function void push_word(logic [15:0] v, logic l, logic t);
      hop_word_t w;
      w.sample = v;
      w.last   = l;
      w.tail   = t;
      pending.push_back(w);
    endfunction

    function void note_input(logic f, logic [15:0] s);
      int unsigned hop, n;
      logic [15:0] v;
      hop = eff_hop();
      if (f == FUNC_SAMPLE) begin
        if (fill >= hop) fill = 0;
        hop_mem[fill % HOP_MAX_DEF] = s;
        fill++;
        if (fill < hop) return;
        for (int k = 0; k < hop; k++) push_word(hop_mem[k], k + 1 == hop, 1'b0);
        fill = 0;
        return;
      end
      n    = fill;
      fill = 0;
      if (n == 0 || n >= hop) return;
      tail_hops++;
      for (int k = 0; k < hop; k++) begin
        v = '0;
        if (k < n) begin
          if (n == 1) v = hop_mem[0];
          else v = scale(hop_mem[k], fade_gain(k, n - 1));
        end
        push_word(v, k + 1 == hop, 1'b1);
      end
    endfunction

    function void check_word(logic [15:0] s, logic l, logic t);
      hop_word_t w;
      words_seen++;
      if (t) tail_words++;
      if (pending.size() == 0) begin
        $error("unexpected output word sample=%0d last=%0b tail=%0b", $signed(s), l, t);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.sample !== s) begin
        $error("sample_out: expected %0d, got %0d", $signed(w.sample), $signed(s));
        errors++;
      end
      if (w.last !== l) begin
        $error("hop_last: expected %0b, got %0b", w.last, l);
        errors++;
      end
      if (w.tail !== t) begin
        $error("tail_hop: expected %0b, got %0b", w.tail, t);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel, penable, pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     func_i;
  logic signed [15:0]       sample_in_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [15:0]       sample_out_o;
  logic                     hop_last_o;
  logic                     tail_hop_o;

  hop_scoreboard sb;
  int send_idle_pct;   // chance in 100 of a gap before each input word
  int recv_idle_pct;   // chance in 100 that out_ready is low in a cycle
  int words_sent;
  int cfg_writes;

  hop_framer_with_tail_fadeout u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .hop_last_o   (hop_last_o),
    .tail_hop_o   (tail_hop_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #40ms;
    $display("timeout with %0d words still expected", sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

  // output side: check each accepted word, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(sample_out_o, hop_last_o, tail_hop_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input word; valid stays high back to back when no gap is drawn
  task automatic send_word(logic f, logic [15:0] s);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(f, s);
    words_sent++;
  endtask

  // let the block drain; samples that complete no hop leave no trace to wait on
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // APB write: setup then access; pready is always high
  task automatic cfg_write(logic [ADDR_W-1:0] a, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == 0) sb.write_hop(v);   // address 4, the only other one used, is ignored
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // junk in the upper data bits must not matter
  task automatic set_hop(logic [6:0] h);
    drain();
    cfg_write(ADDR_W'(4 * REG_HOP_LEN), {8'($urandom_range(255)), 17'd0, h});
  endtask

  // one stream: mostly well-formed runs of samples ended by an end word
  task automatic random_stream();
    int unsigned hop, len;
    hop = sb.eff_hop();
    case ($urandom_range(9))
      0:       len = 0;
      1:       len = hop;
      2:       len = hop * $urandom_range(1, 2) + $urandom_range(hop - 1);
      default: len = $urandom_range(hop);
    endcase
    if (len > 140) len = 140;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) send_word(FUNC_END, 16'($urandom));   // noise
      else send_word(FUNC_SAMPLE, 16'($urandom));
    end
    send_word(FUNC_END, 16'($urandom));
  endtask

  logic [6:0] hop_pick;
  int         budget;

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_SAMPLE;
    sample_in_i   = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 77;
    words_sent    = 0;
    cfg_writes    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: hop of 4, extremes of the sample range in a full hop
    set_hop(7'd4);
    send_word(FUNC_SAMPLE, 16'h7FFF);
    send_word(FUNC_SAMPLE, 16'h8000);
    send_word(FUNC_SAMPLE, 16'h0000);
    send_word(FUNC_SAMPLE, 16'hFFFF);
    send_word(FUNC_END, 16'h1234);        // ends on a boundary: nothing out
    // three-sample tail: full, mid and zero gain
    send_word(FUNC_SAMPLE, 16'h8000);
    send_word(FUNC_SAMPLE, 16'h7FFF);
    send_word(FUNC_SAMPLE, 16'h7FFF);
    send_word(FUNC_END, 16'hFFFF);
    // single-sample tail passes unchanged
    send_word(FUNC_SAMPLE, 16'h8001);
    send_word(FUNC_END, 16'h0000);
    send_word(FUNC_END, 16'h5555);        // empty stream
    // partial hop dropped by a register write
    send_word(FUNC_SAMPLE, 16'h0101);
    send_word(FUNC_SAMPLE, 16'h0202);
    drain();
    cfg_write(3'd4, 32'd9);               // unmapped address: no effect
    set_hop(7'd2);
    send_word(FUNC_SAMPLE, 16'hAAAA);
    send_word(FUNC_END, 16'h0000);
    // zero hop length acts as one
    set_hop(7'd0);
    send_word(FUNC_SAMPLE, 16'h8000);
    send_word(FUNC_SAMPLE, 16'h7FFF);
    send_word(FUNC_END, 16'h0000);
    // oversize hop length acts as the maximum
    set_hop(7'd127);
    send_word(FUNC_SAMPLE, 16'h4000);
    send_word(FUNC_SAMPLE, 16'hC000);
    send_word(FUNC_END, 16'h0000);

    // random phases: three idling modes, several hop settings each
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 77 : 0;
      recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 35 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        case ($urandom_range(9))
          0:       hop_pick = 7'd64;
          1:       hop_pick = 7'($urandom_range(65, 127));
          2:       hop_pick = 7'd1;
          3:       hop_pick = 7'd0;
          default: hop_pick = 7'($urandom_range(2, 12));
        endcase
        set_hop(hop_pick);
        budget = words_sent + 18;
        while (words_sent < budget) random_stream();
      end
    end

    drain();
    $display("sent %0d input words across %0d register writes and three idling modes",
             words_sent, cfg_writes);
    $display("checked %0d output words, %0d of them in %0d faded tail hops",
             sb.words_seen, sb.tail_words, sb.tail_hops);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.errors, sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
